// ===== rtl/core/esc_pkg.sv =====
// Shared types, constants, control-store contents and helper functions of the calendar converter.
`timescale 1ns / 1ps

package esc_pkg;

   // Widths of the datapath.
   localparam int ACC_W   = 32;
   localparam int REM_W   = 6;
   localparam int DAYS_W  = 16;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int LEN_W   = 11;
   localparam int STEP_W  = 4;
   localparam int MAG_W   = 31;
   localparam int PROD_W  = 64;

   // Calendar constants.
   localparam logic [YEAR_W-1:0] EPOCH_YEAR     = YEAR_W'(1970);
   localparam logic [ACC_W-1:0]  EPOCH_WEEKDAY  = ACC_W'(4);
   localparam logic [LEN_W-1:0]  QUAD_DAYS      = LEN_W'(1461);
   localparam logic [LEN_W-1:0]  LEAP_DAYS      = LEN_W'(366);
   localparam logic [LEN_W-1:0]  COMMON_DAYS    = LEN_W'(365);
   localparam logic [MONTH_W-1:0] MONTH_LAST    = MONTH_W'(11);

   // Reciprocal division. Division by 60 is a shift by two and then division by 15 of a value
   // below 2^30; division by 24 is a shift by three and then division by 3 of a value below
   // 2^29; division by 7 is applied to a day count, which is always below 2^29. Each magic
   // number is the reciprocal rounded up, and within those ranges the rounding never shows.
   localparam int                PRE_60         = 2;
   localparam int                PRE_24         = 3;
   localparam logic [MAG_W-1:0]  RECIP_15       = MAG_W'(1145324613);
   localparam int                RECIP_15_SHIFT = 34;
   localparam logic [MAG_W-1:0]  RECIP_3        = MAG_W'(715827883);
   localparam int                RECIP_3_SHIFT  = 31;
   localparam logic [MAG_W-1:0]  RECIP_7        = MAG_W'(613566757);
   localparam int                RECIP_7_SHIFT  = 32;

   typedef logic [STEP_W-1:0] step_type;

   // Micro-operations of the datapath.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIV,
      OP_SAVE_SEC,
      OP_SAVE_MIN,
      OP_SAVE_HOUR,
      OP_SAVE_WDAY,
      OP_QUAD,
      OP_YEAR,
      OP_MONTH,
      OP_EMIT
   } op_type;

   // Constant divisor used by a division step.
   typedef enum logic [1:0] {
      DIV_60,
      DIV_24,
      DIV_7
   } div_type;

   // Jump conditions of the sequencer.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_IDLE,
      COND_TAKE,
      COND_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      div_type  div_sel;
      cond_type cond;
      step_type target;
   } ctrl_type;

   // Status returned from the datapath to the sequencer.
   typedef struct packed {
      logic take;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic [31:0] epoch_seconds;
   } req_type;

   typedef struct packed {
      logic [5:0]  seconds;
      logic [5:0]  minutes;
      logic [4:0]  hours;
      logic [2:0]  weekday;
      logic [4:0]  day_of_month;
      logic [3:0]  month_number;
      logic [11:0] full_year;
   } rsp_type;

   // Program addresses.
   localparam step_type STEP_WAIT      = STEP_W'(0);
   localparam step_type STEP_DIV_SEC   = STEP_W'(1);
   localparam step_type STEP_SAVE_SEC  = STEP_W'(2);
   localparam step_type STEP_DIV_MIN   = STEP_W'(3);
   localparam step_type STEP_SAVE_MIN  = STEP_W'(4);
   localparam step_type STEP_DIV_HOUR  = STEP_W'(5);
   localparam step_type STEP_SAVE_HOUR = STEP_W'(6);
   localparam step_type STEP_DIV_WDAY  = STEP_W'(7);
   localparam step_type STEP_SAVE_WDAY = STEP_W'(8);
   localparam step_type STEP_QUAD      = STEP_W'(9);
   localparam step_type STEP_YEAR      = STEP_W'(10);
   localparam step_type STEP_MONTH     = STEP_W'(11);
   localparam step_type STEP_EMIT      = STEP_W'(12);
   localparam step_type STEP_RETURN    = STEP_W'(13);

   // The control store: one control word per program step.
   function automatic ctrl_type esc_ucode(input step_type step);
      ctrl_type w;
      w = '{op: OP_NOP, div_sel: DIV_60, cond: COND_ALWAYS, target: STEP_WAIT};
      unique case (step)
         STEP_WAIT:      w = '{OP_LOAD,      DIV_60, COND_IDLE,  STEP_WAIT};
         STEP_DIV_SEC:   w = '{OP_DIV,       DIV_60, COND_NEVER, STEP_WAIT};
         STEP_SAVE_SEC:  w = '{OP_SAVE_SEC,  DIV_60, COND_NEVER, STEP_WAIT};
         STEP_DIV_MIN:   w = '{OP_DIV,       DIV_60, COND_NEVER, STEP_WAIT};
         STEP_SAVE_MIN:  w = '{OP_SAVE_MIN,  DIV_60, COND_NEVER, STEP_WAIT};
         STEP_DIV_HOUR:  w = '{OP_DIV,       DIV_24, COND_NEVER, STEP_WAIT};
         STEP_SAVE_HOUR: w = '{OP_SAVE_HOUR, DIV_24, COND_NEVER, STEP_WAIT};
         STEP_DIV_WDAY:  w = '{OP_DIV,       DIV_7,  COND_NEVER, STEP_WAIT};
         STEP_SAVE_WDAY: w = '{OP_SAVE_WDAY, DIV_7,  COND_NEVER, STEP_WAIT};
         STEP_QUAD:      w = '{OP_QUAD,      DIV_60, COND_TAKE,  STEP_QUAD};
         STEP_YEAR:      w = '{OP_YEAR,      DIV_60, COND_TAKE,  STEP_YEAR};
         STEP_MONTH:     w = '{OP_MONTH,     DIV_60, COND_TAKE,  STEP_MONTH};
         STEP_EMIT:      w = '{OP_EMIT,      DIV_60, COND_BUSY,  STEP_EMIT};
         STEP_RETURN:    w = '{OP_NOP,       DIV_60, COND_ALWAYS, STEP_WAIT};
         default:        w = '{OP_NOP,       DIV_60, COND_ALWAYS, STEP_WAIT};
      endcase
      return w;
   endfunction

   function automatic logic [REM_W:0] esc_divisor(input div_type sel);
      logic [REM_W:0] d;
      d = (REM_W+1)'(60);
      unique case (sel)
         DIV_60:  d = (REM_W+1)'(60);
         DIV_24:  d = (REM_W+1)'(24);
         DIV_7:   d = (REM_W+1)'(7);
         default: d = (REM_W+1)'(60);
      endcase
      return d;
   endfunction

   // Length of a month (0 is January); February follows the four-year rule.
   function automatic logic [4:0] esc_month_days(input logic [MONTH_W-1:0] m, input logic leap);
      logic [4:0] n;
      n = 5'd31;
      unique case (m)
         4'd1:    n = leap ? 5'd29 : 5'd28;
         4'd3:    n = 5'd30;
         4'd5:    n = 5'd30;
         4'd8:    n = 5'd30;
         4'd10:   n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/core/esc_stream_if.sv =====
// Valid/ready stream interface that carries one word of a given payload type.
`timescale 1ns / 1ps

interface esc_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/esc_sequencer.sv =====
// Step counter and control store that drive the converter datapath.
`timescale 1ns / 1ps

module esc_sequencer import esc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output ctrl_type   ctrl,
   output logic       req_ready
);

   step_type step_ff, step_in;
   logic     jump;

   assign ctrl      = esc_ucode(step_ff);
   assign req_ready = (ctrl.op == OP_LOAD);

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:  jump = 1'b0;
         COND_ALWAYS: jump = 1'b1;
         COND_IDLE:   jump = !req_valid;
         COND_TAKE:   jump = status.take;
         COND_BUSY:   jump = status.out_busy;
         default:     jump = 1'b1;
      endcase
   end

   always_comb begin
      step_in = jump ? ctrl.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/core/esc_datapath.sv =====
// Working registers, reciprocal divider, length compare and result register of the converter.
`timescale 1ns / 1ps

module esc_datapath import esc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   input  logic        req_valid,
   input  req_type     req_word,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output rsp_type     rsp_word,
   output status_type  status
);

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   num_ff, num_in;
   logic [DAYS_W-1:0]  days_ff, days_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [5:0]         sec_ff, sec_in;
   logic [5:0]         min_ff, min_in;
   logic [4:0]         hour_ff, hour_in;
   logic [2:0]         wday_ff, wday_in;
   rsp_type            out_ff, out_in;
   logic               valid_ff, valid_in;

   logic [ACC_W-1:0]   div_arg;
   logic [MAG_W-1:0]   div_mag;
   logic [PROD_W-1:0]  div_prod;
   logic [ACC_W-1:0]   div_quot;
   logic [REM_W:0]     divisor;
   logic [ACC_W-1:0]   rem_full;
   logic [REM_W-1:0]   rem_now;
   logic               leap;
   logic [LEN_W-1:0]   len;
   logic               len_ge;
   logic               take;
   logic               busy;

   // Quotient by one reciprocal multiplication; the remainder follows in the next step from
   // the saved dividend and the quotient.
   always_comb begin
      unique case (ctrl.div_sel)
         DIV_24: begin
            div_arg = acc_ff >> PRE_24;
            div_mag = RECIP_3;
         end
         DIV_7: begin
            div_arg = acc_ff;
            div_mag = RECIP_7;
         end
         default: begin
            div_arg = acc_ff >> PRE_60;
            div_mag = RECIP_15;
         end
      endcase
   end

   assign div_prod = PROD_W'(div_arg) * PROD_W'(div_mag);

   always_comb begin
      unique case (ctrl.div_sel)
         DIV_24:  div_quot = ACC_W'(div_prod >> RECIP_3_SHIFT);
         DIV_7:   div_quot = ACC_W'(div_prod >> RECIP_7_SHIFT);
         default: div_quot = ACC_W'(div_prod >> RECIP_15_SHIFT);
      endcase
   end

   assign divisor  = esc_divisor(ctrl.div_sel);
   assign rem_full = num_ff - (acc_ff * ACC_W'(divisor));
   assign rem_now  = rem_full[REM_W-1:0];

   assign leap = (year_ff[1:0] == 2'b00);

   always_comb begin
      unique case (ctrl.op)
         OP_QUAD:  len = QUAD_DAYS;
         OP_YEAR:  len = leap ? LEAP_DAYS : COMMON_DAYS;
         default:  len = LEN_W'(esc_month_days(month_ff, leap));
      endcase
   end

   assign len_ge = (acc_ff >= ACC_W'(len));
   assign take   = len_ge && ((ctrl.op == OP_QUAD) || (ctrl.op == OP_YEAR) ||
                              ((ctrl.op == OP_MONTH) && (month_ff != MONTH_LAST)));
   assign busy   = valid_ff && !rsp_ready;

   assign status.take     = take;
   assign status.out_busy = busy;

   always_comb begin
      acc_in   = acc_ff;
      num_in   = num_ff;
      days_in  = days_ff;
      year_in  = year_ff;
      month_in = month_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      wday_in  = wday_ff;
      out_in   = out_ff;
      unique case (ctrl.op)
         OP_LOAD: begin
            if (req_valid) begin
               acc_in = req_word.epoch_seconds;
            end
         end
         OP_DIV: begin
            num_in = acc_ff;
            acc_in = div_quot;
         end
         OP_SAVE_SEC: begin
            sec_in = rem_now;
         end
         OP_SAVE_MIN: begin
            min_in = rem_now;
         end
         OP_SAVE_HOUR: begin
            hour_in = rem_now[4:0];
            days_in = acc_ff[DAYS_W-1:0];
            acc_in  = acc_ff + EPOCH_WEEKDAY;
         end
         OP_SAVE_WDAY: begin
            wday_in  = rem_now[2:0];
            acc_in   = ACC_W'(days_ff);
            year_in  = EPOCH_YEAR;
            month_in = '0;
         end
         OP_QUAD: begin
            if (take) begin
               acc_in  = acc_ff - ACC_W'(len);
               year_in = year_ff + YEAR_W'(4);
            end
         end
         OP_YEAR: begin
            if (take) begin
               acc_in  = acc_ff - ACC_W'(len);
               year_in = year_ff + YEAR_W'(1);
            end
         end
         OP_MONTH: begin
            if (take) begin
               acc_in   = acc_ff - ACC_W'(len);
               month_in = month_ff + MONTH_W'(1);
            end
         end
         OP_EMIT: begin
            if (!busy) begin
               out_in.seconds      = sec_ff;
               out_in.minutes      = min_ff;
               out_in.hours        = hour_ff;
               out_in.weekday      = wday_ff;
               out_in.day_of_month = acc_ff[4:0] + 5'd1;
               out_in.month_number = month_ff + MONTH_W'(1);
               out_in.full_year    = year_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if ((ctrl.op == OP_EMIT) && !busy) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      num_ff   <= num_in;
      days_ff  <= days_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      sec_ff   <= sec_in;
      min_ff   <= min_in;
      hour_ff  <= hour_in;
      wday_ff  <= wday_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = out_ff;

`ifndef SYNTHESIS
   // After the four-year steps fewer days than one four-year block remain.
   a_year_residue: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_YEAR) |-> (acc_ff < ACC_W'(QUAD_DAYS)))
      else $error("year step entered with a full four-year block left");

   // The month walk never runs past December.
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_MONTH) |-> (month_ff <= MONTH_LAST))
      else $error("month index beyond December");

   // The day left over at the end lies inside the month found.
   a_day_fits: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_EMIT) |-> (acc_ff < ACC_W'(esc_month_days(month_ff, leap))))
      else $error("day index outside the month");

   // A finished conversion appears on the result side in the next cycle.
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      ((ctrl.op == OP_EMIT) && !busy) |=> valid_ff)
      else $error("emitted word not shown");
`endif

endmodule

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// Top level of the epoch seconds to calendar date and time converter.
`timescale 1ns / 1ps

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into second, minute, hour,
// weekday (0 is Sunday), day of month, month and full year. Every year divisible by four is
// taken as a leap year, so 2100 counts as leap. A small microcoded sequencer walks a fixed
// program of fourteen steps over a plain datapath: a reciprocal multiplication gives the
// quotient by 60, 60 and 24 and, for the weekday, by 7 in one step each, and the following
// step recovers the remainder from it; then the day count is reduced by four-year blocks,
// single years and months, one subtraction a cycle. After the result word is written, a return
// step leads back to the wait step, where the next request word can be taken. One item is
// converted at a time: a new word is accepted on the request side once the previous result is
// in the output register, which holds it until the result side takes it, so the next
// conversion runs while that word waits.
module epoch_seconds_to_calendar import esc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   esc_stream_if.sink   req_chan,
   esc_stream_if.source rsp_chan
);

   ctrl_type   ctrl;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;
   rsp_type    rsp_word;
   req_type    req_word;

   assign req_word = req_chan.payload;

   // The sequencer owns the program counter and decides when a request word is taken.
   esc_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .ctrl      (ctrl),
      .req_ready (req_ready)
   );

   // The datapath does the arithmetic and holds the result word until it is taken.
   esc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_valid (req_chan.valid),
      .req_word  (req_word),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .status    (status)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_word;

endmodule
